### src/mfrd_pkg.sv
// ============================================================================
// mfrd_pkg
// Shared constants, codes and the rectangle geometry record for the
// monochrome frame buffer rectangle engine.
// ============================================================================
`default_nettype none

package mfrd_pkg;

    // Panel and frame store shape
    parameter int ROW_BYTES   = 13;
    parameter int ROWS        = 212;
    parameter int STORE_BYTES = ROW_BYTES * ROWS;
    parameter int ADDR_W      = $clog2(STORE_BYTES);
    parameter int BYTE_W      = $clog2(ROW_BYTES);

    // Coordinate limits on 8-bit coordinates
    parameter logic [7:0] XMAX    = 8'(ROW_BYTES * 8 - 1);
    parameter logic [7:0] YMAX    = 8'(ROWS - 1);
    parameter logic [8:0] PANEL_W = 9'(ROW_BYTES * 8);
    parameter logic [8:0] PANEL_H = 9'(ROWS);

    // Command codes
    parameter logic MODE_DRAW = 1'b0;
    parameter logic MODE_READ = 1'b1;

    // Colour codes; other codes leave pixels unchanged
    parameter logic [1:0] COL_WHITE = 2'd0;
    parameter logic [1:0] COL_BLACK = 2'd1;

    // Status codes
    parameter logic STAT_DONE   = 1'b0;
    parameter logic STAT_REJECT = 1'b1;

    // Geometry of an accepted rectangle, as the mask logic needs it
    typedef struct packed {
        logic [7:0] x;       // left column, also left edge line
        logic [7:0] xe;      // x + w - 1 (wrapped), right edge column
        logic       w_nz;    // width at least one: horizontal lines paint
        logic       xr_ok;   // right edge column lies on the panel
        logic [7:0] ix_lo;   // first interior column
        logic [7:0] ix_hi;   // last interior column
        logic       w_ge3;   // interior has columns
        logic [7:0] y;       // top row
        logic [7:0] yb;      // y + h - 1 (wrapped), bottom row
        logic       yb_ok;   // bottom row lies on the panel
        logic       h_ge3;   // side edges and interior have rows
        logic       solid;
        logic [1:0] bc;
        logic [1:0] fc;
    } geom_t;

endpackage

`default_nettype wire

### src/mfrd_mask.sv
// ============================================================================
// mfrd_mask
// Builds the set and clear masks for one frame store byte of one row from
// the rectangle geometry: edge pixels take the border colour, interior
// pixels the fill colour.
// ============================================================================
`default_nettype none

module mfrd_mask (
    input  wire mfrd_pkg::geom_t              geom,
    input  wire logic [7:0]                   row,
    input  wire logic [mfrd_pkg::BYTE_W-1:0]  byte_idx,
    output logic [7:0]                        set_mask,
    output logic [7:0]                        clr_mask
);

    logic hline;
    logic vrow;
    logic frow;

    // Classify the row: top or bottom line, side edge row, interior row
    always_comb
    begin
        hline = (row == geom.y) || (geom.yb_ok && (row == geom.yb));
        vrow  = geom.h_ge3 && (row > geom.y) && (row < geom.yb);
        frow  = vrow && geom.solid && geom.w_ge3;
    end

    // Classify each pixel of the byte; bit 7 is the leftmost column
    always_comb
    begin : pix_loop
        logic [7:0] col;
        logic       edge_pix;
        logic       fill_pix;
        set_mask = '0;
        clr_mask = '0;
        for (int i = 0; i < 8; i++)
        begin
            col      = 8'({byte_idx, 3'(7 - i)});
            edge_pix = (hline && geom.w_nz && (col >= geom.x) && (col <= geom.xe))
                     || (vrow && ((col == geom.x) || (geom.xr_ok && (col == geom.xe))));
            fill_pix = frow && (col >= geom.ix_lo) && (col <= geom.ix_hi);
            set_mask[i] = (edge_pix && (geom.bc == mfrd_pkg::COL_BLACK))
                        || (fill_pix && (geom.fc == mfrd_pkg::COL_BLACK));
            clr_mask[i] = (edge_pix && (geom.bc == mfrd_pkg::COL_WHITE))
                        || (fill_pix && (geom.fc == mfrd_pkg::COL_WHITE));
        end
    end

endmodule

`default_nettype wire

### src/mono_framebuffer_rect_draw.sv
// A read or a rejected command goes from acceptance straight to the result state.
// A draw scans its window one frame store byte per cycle through the single
// read-modify-write port; the next command is taken once the result is loaded.
// in_ready is high only in idle, so a new command waits until the previous one has loaded its result.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes every byte of the
// frame store while in_ready stays low.
// ============================================================================
// mono_framebuffer_rect_draw
// 1 bit per pixel frame store with a rectangle draw engine and a byte read
// command. The store is one synchronous RAM scanned byte by byte.
// ============================================================================
`default_nettype none

module mono_framebuffer_rect_draw (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        mode,
    input  wire logic [7:0]  x_start,
    input  wire logic [7:0]  y_start,
    input  wire logic [7:0]  rect_width,
    input  wire logic [7:0]  rect_height,
    input  wire logic        solid,
    input  wire logic [1:0]  border_colour,
    input  wire logic [1:0]  fill_colour,
    input  wire logic [11:0] read_index,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       read_byte,
    output logic             status
);

    localparam int AW = mfrd_pkg::ADDR_W;
    localparam int BW = mfrd_pkg::BYTE_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DRAW,
        S_RESULT
    } state_t;

    state_t               state_reg;
    logic [AW-1:0]        clr_addr_reg;
    mfrd_pkg::geom_t      geom_reg;
    mfrd_pkg::geom_t      geom_next;
    logic [7:0]           row_reg;
    logic [7:0]           rhi_reg;
    logic [BW-1:0]        byte_reg;
    logic [BW-1:0]        blo_reg;
    logic [BW-1:0]        bhi_reg;
    logic [AW-1:0]        base_reg;
    logic                 wr_pend_reg;
    logic [AW-1:0]        wr_addr_reg;
    logic [7:0]           set_reg;
    logic [7:0]           clr_reg;
    logic                 res_read_reg;
    logic                 res_status_reg;
    logic                 out_valid_reg;
    logic [7:0]           read_byte_reg;
    logic                 status_reg;

    logic [7:0]           store_mem [mfrd_pkg::STORE_BYTES];
    logic [7:0]           rd_data_reg;

    logic                 accept;
    logic                 reject;
    logic                 idx_ok;
    logic [8:0]           x_sum;
    logic [8:0]           y_sum;
    logic [7:0]           lo_col;
    logic [7:0]           hi_col;
    logic [7:0]           rlo;
    logic [7:0]           rhi;
    logic [AW-1:0]        issue_addr;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [7:0]           wr_data;
    logic [7:0]           set_mask;
    logic [7:0]           clr_mask;
    logic                 last_byte;
    logic                 out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign read_byte = read_byte_reg;
    assign status    = status_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Check the command: bounds of the rectangle and of the read index
    always_comb
    begin
        x_sum  = {1'b0, x_start} + {1'b0, rect_width};
        y_sum  = {1'b0, y_start} + {1'b0, rect_height};
        reject = (x_start > mfrd_pkg::XMAX) || (y_start > mfrd_pkg::YMAX)
              || (x_sum > mfrd_pkg::PANEL_W) || (y_sum > mfrd_pkg::PANEL_H);
        idx_ok = read_index < AW'(mfrd_pkg::STORE_BYTES);
    end

    // Derive the edge and interior geometry and the scan window
    always_comb
    begin
        geom_next.x     = x_start;
        geom_next.xe    = x_start + rect_width - 8'd1;
        geom_next.w_nz  = (rect_width != 8'd0);
        geom_next.xr_ok = geom_next.xe <= mfrd_pkg::XMAX;
        geom_next.ix_lo = x_start + 8'd1;
        geom_next.ix_hi = x_start + rect_width - 8'd2;
        geom_next.w_ge3 = (rect_width >= 8'd3);
        geom_next.y     = y_start;
        geom_next.yb    = y_start + rect_height - 8'd1;
        geom_next.yb_ok = geom_next.yb <= mfrd_pkg::YMAX;
        geom_next.h_ge3 = (rect_height >= 8'd3);
        geom_next.solid = solid;
        geom_next.bc    = border_colour;
        geom_next.fc    = fill_colour;

        lo_col = ((rect_width == 8'd0) && (x_start != 8'd0)) ? x_start - 8'd1 : x_start;
        hi_col = (rect_width == 8'd0) ? x_start : geom_next.xe;
        rlo    = ((rect_height == 8'd0) && (y_start != 8'd0)) ? y_start - 8'd1 : y_start;
        rhi    = (rect_height == 8'd0) ? y_start : geom_next.yb;
    end

    // Masks for the byte issued this cycle
    mfrd_mask u_mask (
        .geom     (geom_reg),
        .row      (row_reg),
        .byte_idx (byte_reg),
        .set_mask (set_mask),
        .clr_mask (clr_mask)
    );

    // Select the RAM accesses: clear sweep, draw scan, or byte read
    always_comb
    begin
        issue_addr = base_reg + AW'(byte_reg);
        last_byte  = (byte_reg == bhi_reg) && (row_reg == rhi_reg);
        rd_en      = 1'b0;
        rd_addr    = issue_addr;
        if (state_reg == S_DRAW)
        begin
            rd_en = 1'b1;
        end
        else if (accept && (mode == mfrd_pkg::MODE_READ) && idx_ok)
        begin
            rd_en   = 1'b1;
            rd_addr = read_index;
        end
        wr_en   = (state_reg == S_CLEAR) || wr_pend_reg;
        wr_addr = (state_reg == S_CLEAR) ? clr_addr_reg : wr_addr_reg;
        wr_data = (state_reg == S_CLEAR) ? 8'd0 : ((rd_data_reg & ~clr_reg) | set_reg);
    end

    // Frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // Sequencer: clear pass, command decode, byte scan, result hand-off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            geom_reg       <= '0;
            row_reg        <= '0;
            rhi_reg        <= '0;
            byte_reg       <= '0;
            blo_reg        <= '0;
            bhi_reg        <= '0;
            base_reg       <= '0;
            wr_pend_reg    <= 1'b0;
            wr_addr_reg    <= '0;
            set_reg        <= '0;
            clr_reg        <= '0;
            res_read_reg   <= 1'b0;
            res_status_reg <= mfrd_pkg::STAT_DONE;
            out_valid_reg  <= 1'b0;
            read_byte_reg  <= '0;
            status_reg     <= mfrd_pkg::STAT_DONE;
        end
        else
        begin
            // Drop the output transaction once taken, unless a new one loads now
            if (out_valid_reg && out_ready && (state_reg != S_RESULT))
            begin
                out_valid_reg <= 1'b0;
            end

            // Write stage follows each issued read in the next cycle
            wr_pend_reg <= (state_reg == S_DRAW);
            wr_addr_reg <= issue_addr;
            set_reg     <= set_mask;
            clr_reg     <= clr_mask;

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == AW'(mfrd_pkg::STORE_BYTES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_IDLE:
                begin
                    if (accept)
                    begin
                        geom_reg     <= geom_next;
                        row_reg      <= rlo;
                        rhi_reg      <= rhi;
                        byte_reg     <= lo_col[3 +: BW];
                        blo_reg      <= lo_col[3 +: BW];
                        bhi_reg      <= hi_col[3 +: BW];
                        base_reg     <= AW'(rlo * mfrd_pkg::ROW_BYTES);
                        res_read_reg <= (mode == mfrd_pkg::MODE_READ) && idx_ok;
                        if (mode == mfrd_pkg::MODE_READ)
                        begin
                            res_status_reg <= idx_ok ? mfrd_pkg::STAT_DONE
                                                     : mfrd_pkg::STAT_REJECT;
                            state_reg      <= S_RESULT;
                        end
                        else if (reject)
                        begin
                            res_status_reg <= mfrd_pkg::STAT_REJECT;
                            state_reg      <= S_RESULT;
                        end
                        else
                        begin
                            res_status_reg <= mfrd_pkg::STAT_DONE;
                            state_reg      <= S_DRAW;
                        end
                    end
                end

                S_DRAW:
                begin
                    // Advance along the row, then down to the next row
                    if (byte_reg == bhi_reg)
                    begin
                        byte_reg <= blo_reg;
                        row_reg  <= row_reg + 8'd1;
                        base_reg <= base_reg + AW'(mfrd_pkg::ROW_BYTES);
                    end
                    else
                    begin
                        byte_reg <= byte_reg + BW'(1);
                    end
                    if (last_byte)
                    begin
                        state_reg <= S_RESULT;
                    end
                end

                S_RESULT:
                begin
                    // Hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        read_byte_reg <= res_read_reg ? rd_data_reg : 8'd0;
                        status_reg    <= res_status_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A read never targets the byte being written back
    assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write hit the same frame store byte");

    // Write-back addresses stay inside the store
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_addr < AW'(mfrd_pkg::STORE_BYTES)))
        else $error("write address beyond the frame store");

    // The scan stays inside its row and byte window
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAW) |-> ((row_reg <= rhi_reg) && (byte_reg >= blo_reg)
                                   && (byte_reg <= bhi_reg)))
        else $error("draw scan left its window");

    // A result only appears after the result state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_RESULT))
        else $error("result without a finished command");

    // No command is taken while the store is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |=> !$past(accept))
        else $error("command accepted during clearing pass");

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the monochrome frame buffer rectangle engine
// Walks a table of directed commands (bounds, degenerate sizes, colour codes,
// bad read indexes), then random draw and read commands with random gaps on
// both handshakes. A shadow frame store predicts the untyped results; each
// result is compared field by field against the result stream in order.
// ----------------------------------------------------------------------------
module tb_top;

    // Constants and codes taken from the package
    localparam logic        MODE_DRAW   = mfrd_pkg::MODE_DRAW;
    localparam logic        MODE_READ   = mfrd_pkg::MODE_READ;
    localparam logic [1:0]  COL_WHITE   = mfrd_pkg::COL_WHITE;
    localparam logic [1:0]  COL_BLACK   = mfrd_pkg::COL_BLACK;
    localparam logic        STAT_DONE   = mfrd_pkg::STAT_DONE;
    localparam logic        STAT_REJECT = mfrd_pkg::STAT_REJECT;
    localparam int          ROW_BYTES   = mfrd_pkg::ROW_BYTES;
    localparam int          STORE_BYTES = mfrd_pkg::STORE_BYTES;
    localparam logic [7:0]  XMAX        = mfrd_pkg::XMAX;
    localparam logic [7:0]  YMAX        = mfrd_pkg::YMAX;
    localparam logic [8:0]  PANEL_W     = mfrd_pkg::PANEL_W;
    localparam logic [8:0]  PANEL_H     = mfrd_pkg::PANEL_H;

    localparam int          RAND_ITEMS   = 600;
    localparam int          DRAIN_EVERY  = 100;
    localparam int          TAIL_CYCLES  = 20;
    localparam int          LIMIT_CYCLES = 5_000_000;
    localparam int          DIR_N        = 25;
    localparam logic [1:0]  COL_KEEP     = 2'd2;
    localparam logic [1:0]  COL_KEEP_ALT = 2'd3;

    // One command plus, for rows whose answer is obvious, the typed result
    typedef struct packed {
        logic        mode;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  w;
        logic [7:0]  h;
        logic        solid;
        logic [1:0]  bc;
        logic [1:0]  fc;
        logic [11:0] ridx;
        logic        typed;
        logic [7:0]  t_byte;
        logic        t_stat;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] rbyte;
        logic       stat;
    } frame_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        mode;
    logic [7:0]  x_start;
    logic [7:0]  y_start;
    logic [7:0]  rect_width;
    logic [7:0]  rect_height;
    logic        solid;
    logic [1:0]  border_colour;
    logic [1:0]  fill_colour;
    logic [11:0] read_index;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  read_byte;
    logic        status;

    logic [7:0]    fb_shadow [STORE_BYTES];
    frame_result_t pending_results [$];
    frame_result_t head_result;
    int            mismatches = 0;
    int            cycle_cnt  = 0;
    bit            tx_burst   = 1'b0;
    bit            rx_burst   = 1'b0;
    logic [7:0]    last_x     = 8'd0;
    logic [7:0]    last_y     = 8'd0;

    // Directed commands: reads after reset, every reject reason, full panel
    // paints, one-row, one-column, point, zero height and zero width shapes
    stim_row_t dir_tab [DIR_N] = '{
        '{MODE_READ, 0, 0, 0, 0, 0, COL_WHITE, COL_WHITE, 12'd0, 1, 8'h00, STAT_DONE},
        '{MODE_READ, 0, 0, 0, 0, 0, COL_WHITE, COL_WHITE, 12'(STORE_BYTES - 1),
          1, 8'h00, STAT_DONE},
        '{MODE_READ, 0, 0, 0, 0, 0, COL_WHITE, COL_WHITE, 12'(STORE_BYTES),
          1, 8'h00, STAT_REJECT},
        '{MODE_READ, 0, 0, 0, 0, 0, COL_WHITE, COL_WHITE, 12'hFFF, 1, 8'h00, STAT_REJECT},
        '{MODE_DRAW, 255, 0, 1, 1, 1, COL_BLACK, COL_BLACK, 12'd0, 1, 8'h00, STAT_REJECT},
        '{MODE_DRAW, 0, 255, 1, 1, 1, COL_BLACK, COL_BLACK, 12'd0, 1, 8'h00, STAT_REJECT},
        '{MODE_DRAW, 100, 0, 5, 1, 0, COL_BLACK, COL_BLACK, 12'd0, 1, 8'h00, STAT_REJECT},
        '{MODE_DRAW, 0, 200, 1, 13, 0, COL_BLACK, COL_BLACK, 12'd0, 1, 8'h00, STAT_REJECT},
        '{MODE_DRAW, 0, 0, 255, 1, 0, COL_BLACK, COL_BLACK, 12'd0, 1, 8'h00, STAT_REJECT},
        '{MODE_DRAW, 0, 0, 1, 255, 0, COL_BLACK, COL_BLACK, 12'd0, 1, 8'h00, STAT_REJECT},
        '{MODE_DRAW, 0, 0, 104, 212, 1, COL_BLACK, COL_BLACK, 12'd0, 1, 8'h00, STAT_DONE},
        '{MODE_READ, 0, 0, 0, 0, 0, COL_WHITE, COL_WHITE, 12'd0, 1, 8'hFF, STAT_DONE},
        '{MODE_READ, 0, 0, 0, 0, 0, COL_WHITE, COL_WHITE, 12'(STORE_BYTES - 1),
          1, 8'hFF, STAT_DONE},
        '{MODE_DRAW, 0, 0, 104, 212, 0, COL_WHITE, COL_KEEP, 12'd0, 1, 8'h00, STAT_DONE},
        '{MODE_READ, 0, 0, 0, 0, 0, COL_WHITE, COL_WHITE, 12'd0, 1, 8'h00, STAT_DONE},
        '{MODE_READ, 0, 0, 0, 0, 0, COL_WHITE, COL_WHITE, 12'(ROW_BYTES),
          1, 8'h7F, STAT_DONE},
        '{MODE_DRAW, 8, 8, 16, 12, 1, COL_WHITE, COL_KEEP_ALT, 12'd0, 0, 8'h00, STAT_DONE},
        '{MODE_DRAW, 10, 5, 20, 1, 1, COL_WHITE, COL_BLACK, 12'd0, 0, 8'h00, STAT_DONE},
        '{MODE_DRAW, 50, 30, 1, 10, 1, COL_WHITE, COL_BLACK, 12'd0, 0, 8'h00, STAT_DONE},
        '{MODE_DRAW, 103, 211, 1, 1, 0, COL_WHITE, COL_WHITE, 12'd0, 0, 8'h00, STAT_DONE},
        '{MODE_DRAW, 20, 40, 16, 0, 1, COL_WHITE, COL_BLACK, 12'd0, 0, 8'h00, STAT_DONE},
        '{MODE_DRAW, 30, 50, 0, 5, 1, COL_WHITE, COL_WHITE, 12'd0, 0, 8'h00, STAT_DONE},
        '{MODE_DRAW, 0, 0, 0, 0, 1, COL_WHITE, COL_BLACK, 12'd0, 0, 8'h00, STAT_DONE},
        '{MODE_READ, 0, 0, 0, 0, 0, COL_WHITE, COL_WHITE, 12'(39 * ROW_BYTES + 2),
          0, 8'h00, STAT_DONE},
        '{MODE_READ, 0, 0, 0, 0, 0, COL_WHITE, COL_WHITE, 12'(51 * ROW_BYTES + 3),
          0, 8'h00, STAT_DONE}
    };

    mono_framebuffer_rect_draw dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .x_start       (x_start),
        .y_start       (y_start),
        .rect_width    (rect_width),
        .rect_height   (rect_height),
        .solid         (solid),
        .border_colour (border_colour),
        .fill_colour   (fill_colour),
        .read_index    (read_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_byte     (read_byte),
        .status        (status)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Set or clear one pixel of the shadow store; other colours leave it
    function automatic void paint_px(logic [7:0] px, logic [7:0] py, logic [1:0] colour);
        int         idx;
        logic [7:0] mask;
        if (px > XMAX || py > YMAX)
            return;
        idx  = int'(py) * ROW_BYTES + int'(px >> 3);
        mask = 8'h80 >> px[2:0];
        if (colour == COL_WHITE)
            fb_shadow[idx] = fb_shadow[idx] & ~mask;
        else if (colour == COL_BLACK)
            fb_shadow[idx] = fb_shadow[idx] | mask;
    endfunction

    // Paint one line; drop it whole if its start or end leaves the panel
    function automatic void paint_run(logic [7:0] sx, logic [7:0] sy, logic [7:0] len,
                                      bit horiz, logic [1:0] colour);
        if (sx > XMAX || sy > YMAX)
            return;
        if (horiz && int'(sx) + int'(len) - 1 > int'(XMAX))
            return;
        if (!horiz && int'(sy) + int'(len) - 1 > int'(YMAX))
            return;
        for (int i = 0; i < int'(len); i++)
        begin
            paint_px(sx, sy, colour);
            if (horiz)
                sx = sx + 8'd1;
            else
                sy = sy + 8'd1;
        end
    endfunction

    // Apply one command to the shadow store and return its result
    function automatic frame_result_t apply_frame_cmd(stim_row_t c);
        frame_result_t r;
        logic [7:0]    vlen;
        logic [7:0]    row;
        int            rows;
        r.rbyte = 8'h00;
        r.stat  = STAT_DONE;
        if (c.mode == MODE_READ)
        begin
            if (int'(c.ridx) < STORE_BYTES)
                r.rbyte = fb_shadow[c.ridx];
            else
                r.stat = STAT_REJECT;
            return r;
        end
        if (c.x > XMAX || c.y > YMAX ||
            int'(c.x) + int'(c.w) - 1 > int'(XMAX) ||
            int'(c.y) + int'(c.h) - 1 > int'(YMAX))
        begin
            r.stat = STAT_REJECT;
            return r;
        end
        vlen = c.h - 8'd2;
        paint_run(c.x, c.y, c.w, 1'b1, c.bc);
        paint_run(c.x, c.y + c.h - 8'd1, c.w, 1'b1, c.bc);
        paint_run(c.x, c.y + 8'd1, vlen, 1'b0, c.bc);
        paint_run(c.x + c.w - 8'd1, c.y + 8'd1, vlen, 1'b0, c.bc);
        if (c.solid)
        begin
            rows = int'(c.h) - 2;
            row  = c.y + 8'd1;
            for (int i = 0; i < rows; i++)
            begin
                paint_run(c.x + 8'd1, row, c.w - 8'd2, 1'b1, c.fc);
                row = row + 8'd1;
            end
        end
        return r;
    endfunction

    // Random command: mostly reads and small in-panel rectangles, a few
    // large ones, the rest raw field values that are mostly rejected
    function automatic stim_row_t gen_random();
        stim_row_t r;
        int        kind;
        int        wv;
        int        hv;
        r       = '0;
        r.mode  = MODE_DRAW;
        r.x     = 8'($urandom);
        r.y     = 8'($urandom);
        r.w     = 8'($urandom);
        r.h     = 8'($urandom);
        r.solid = 1'($urandom_range(0, 1));
        r.bc    = 2'($urandom_range(0, 3));
        r.fc    = 2'($urandom_range(0, 3));
        r.ridx  = 12'($urandom);
        kind    = $urandom_range(0, 99);
        if (kind < 40)
        begin
            r.mode = MODE_READ;
            if ($urandom_range(0, 1))
                r.ridx = 12'((int'(last_y) + $urandom_range(0, 15)) * ROW_BYTES
                             + int'(last_x >> 3) + $urandom_range(0, 3));
            else if ($urandom_range(0, 9) != 0)
                r.ridx = 12'($urandom_range(0, STORE_BYTES - 1));
        end
        else if (kind < 90)
        begin
            if (kind < 85)
            begin
                wv = $urandom_range(0, 24);
                hv = $urandom_range(0, 16);
            end
            else
            begin
                wv = $urandom_range(0, int'(PANEL_W));
                hv = $urandom_range(0, int'(PANEL_H));
            end
            r.w = 8'(wv);
            r.h = 8'(hv);
            r.x = 8'($urandom_range(0, int'(PANEL_W) - wv));
            r.y = 8'($urandom_range(0, int'(PANEL_H) - hv));
        end
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 39) == 0)
            tx_burst = !tx_burst;
        return tx_burst ? 0 : $urandom_range(0, 15);
    endfunction

    task automatic note_mismatch(string what, int exp_v, int act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, exp_v, act_v);
    endtask

    // Send one command; optionally hold off until all results are back
    task automatic send_cmd(stim_row_t c, int gap, bit drain);
        frame_result_t r;
        if (drain && gap == 0)
            gap = 1;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            while (drain && pending_results.size() != 0)
                @(posedge clk);
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= c.mode;
        x_start       <= c.x;
        y_start       <= c.y;
        rect_width    <= c.w;
        rect_height   <= c.h;
        solid         <= c.solid;
        border_colour <= c.bc;
        fill_colour   <= c.fc;
        read_index    <= c.ridx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // transaction taken at this edge
        r = apply_frame_cmd(c);
        if (c.typed)
        begin
            r.rbyte = c.t_byte;
            r.stat  = c.t_stat;
        end
        pending_results.push_back(r);
        if (c.mode == MODE_DRAW)
        begin
            last_x = c.x;
            last_y = c.y;
        end
    endtask

    // Stimulus
    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        mode          = MODE_DRAW;
        x_start       = 8'd0;
        y_start       = 8'd0;
        rect_width    = 8'd0;
        rect_height   = 8'd0;
        solid         = 1'b0;
        border_colour = COL_WHITE;
        fill_colour   = COL_WHITE;
        read_index    = 12'd0;
        foreach (fb_shadow[i])
            fb_shadow[i] = 8'h00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        foreach (dir_tab[i])
            send_cmd(dir_tab[i], pick_gap(), 1'b0);
        for (int n = 0; n < RAND_ITEMS; n++)
            send_cmd(gen_random(), pick_gap(), (n % DRAIN_EVERY) == 0);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Result side: random stalls, with stretches of none
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                note_mismatch("unexpected result, read_byte", 0, read_byte);
            else
            begin
                head_result = pending_results.pop_front();
                if (read_byte !== head_result.rbyte)
                    note_mismatch("read_byte", head_result.rbyte, read_byte);
                if (status !== head_result.stat)
                    note_mismatch("status", head_result.stat, status);
            end
        end
    end

    // Hang guard
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
